>>> rtl/core/prup_pkg.sv
// Package with the beat types, register codes and lane constants of the pixel reorder block.
package prup_pkg;

  localparam int unsigned LANES = 3;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;
  localparam logic [7:0] ALPHA_ZERO = 8'h00;
  localparam logic [7:0] BYTE_SAT = 8'hFF;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_pixel_in;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_pixel_out;
  } out_t;

  typedef enum logic [1:0] {
    CFG_PIXEL_ORDER      = 2'd0,
    CFG_EXPORT_DIRECTION = 2'd1,
    CFG_UNDO_PREMULTIPLY = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stg_en_t;

endpackage

>>> rtl/core/prup_lane.sv
// One color channel lane: numerator build, restoring division by alpha and saturation.
module prup_lane (
  input  logic              clk,
  input  prup_pkg::stg_en_t en,
  input  logic [7:0]        chan,
  input  logic [7:0]        alpha,
  output logic [7:0]        result
);

  logic [15:0] num1_r;
  logic [7:0]  a1_r;
  logic [15:0] rem2_r;
  logic [15:0] rem2_nxt;
  logic [3:0]  qhi2_r;
  logic [3:0]  qhi2_nxt;
  logic [7:0]  a2_r;
  logic        sat2_r;
  logic        sat2_nxt;
  logic [7:0]  q3_r;
  logic [3:0]  qlo3_nxt;
  logic        sat3_r;

  // The numerator c*255 + floor(a/2) never exceeds 16 bits.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      num1_r <= {chan, 8'h00} - {8'h00, chan} + {9'h000, alpha[7:1]};
      a1_r   <= alpha;
    end
  end

  always_comb begin
    logic [15:0] rem;
    logic [15:0] dvs;
    rem = num1_r;
    qhi2_nxt = '0;
    sat2_nxt = (num1_r >= {a1_r, 8'h00});
    for (int i = 0; i < prup_pkg::STEPS_PER_STAGE; i++) begin
      dvs = {8'h00, a1_r} << (7 - i);
      if (rem >= dvs) begin
        rem = rem - dvs;
        qhi2_nxt[3 - i] = 1'b1;
      end
    end
    rem2_nxt = rem;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rem2_r <= rem2_nxt;
      qhi2_r <= qhi2_nxt;
      a2_r   <= a1_r;
      sat2_r <= sat2_nxt;
    end
  end

  always_comb begin
    logic [15:0] rem;
    logic [15:0] dvs;
    rem = rem2_r;
    qlo3_nxt = '0;
    for (int i = 0; i < prup_pkg::STEPS_PER_STAGE; i++) begin
      dvs = {8'h00, a2_r} << (3 - i);
      if (rem >= dvs) begin
        rem = rem - dvs;
        qlo3_nxt[3 - i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      q3_r   <= {qhi2_r, qlo3_nxt};
      sat3_r <= sat2_r;
    end
  end

  assign result = sat3_r ? prup_pkg::BYTE_SAT : q3_r;

endmodule

>>> rtl/core/prup_merge.sv
// Merge stage: output register gets lane quotients and alpha byte, or the word unchanged.
module prup_merge (
  input  logic                         clk,
  input  logic                         load,
  input  logic [31:0]                  word,
  input  logic                         last,
  input  logic                         use_div,
  input  logic [prup_pkg::LANES-1:0][7:0] lane_q,
  output prup_pkg::out_t               out_data
);

  prup_pkg::out_t out_data_r;
  prup_pkg::out_t out_data_nxt;

  always_comb begin
    out_data_nxt.last_pixel_out = last;
    if (use_div) begin
      out_data_nxt.pixel_out = {word[31:24], lane_q[2], lane_q[1], lane_q[0]};
    end else begin
      out_data_nxt.pixel_out = word;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> rtl/core/pixel_reorder_unpremultiply.sv
// Top level of the pixel byte reorder and alpha unpremultiply block.
// An accepted beat passes stages 0 to 3 and the output register before out_valid.
// Throughput: one beat per cycle unless out_ready stalls; three channel lanes divide
// by alpha in parallel, four quotient bits per stage over two pipeline stages.
// Reset is synchronous and active low; it clears the stage valid bits and the
// configuration registers, which all return to zero.
module pixel_reorder_unpremultiply (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prup_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prup_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic           cfg_data
);

  logic pixel_order_r;
  logic export_direction_r;
  logic undo_premultiply_r;

  logic v0_r, v1_r, v2_r, v3_r, out_v_r;
  logic en0, en1, en2, en3, ld_out;
  prup_pkg::stg_en_t lane_en;

  logic [31:0] w_in;
  logic        div_in;
  logic [31:0] w0_r, w1_r, w2_r, w3_r;
  logic        last0_r, last1_r, last2_r, last3_r;
  logic        div0_r, div1_r, div2_r, div3_r;
  logic [prup_pkg::LANES-1:0][7:0] lane_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_order_r      <= 1'b0;
      export_direction_r <= 1'b0;
      undo_premultiply_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (prup_pkg::cfg_reg_t'(cfg_index))
        prup_pkg::CFG_PIXEL_ORDER:      pixel_order_r      <= cfg_data;
        prup_pkg::CFG_EXPORT_DIRECTION: export_direction_r <= cfg_data;
        prup_pkg::CFG_UNDO_PREMULTIPLY: undo_premultiply_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ld_out   = !out_v_r || out_ready;
  assign en3      = !v3_r || ld_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;
  assign lane_en  = '{s1: en1, s2: en2, s3: en3};

  always_comb begin
    w_in = in_data.pixel_in;
    if (pixel_order_r) begin
      if (export_direction_r) begin
        w_in = {in_data.pixel_in[23:0], in_data.pixel_in[31:24]};
      end else begin
        w_in = {in_data.pixel_in[7:0], in_data.pixel_in[31:8]};
      end
    end
    div_in = undo_premultiply_r && !export_direction_r &&
             (w_in[31:24] != prup_pkg::ALPHA_ZERO) &&
             (w_in[31:24] != prup_pkg::ALPHA_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en0)    v0_r    <= in_valid;
      if (en1)    v1_r    <= v0_r;
      if (en2)    v2_r    <= v1_r;
      if (en3)    v3_r    <= v2_r;
      if (ld_out) out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      w0_r    <= w_in;
      last0_r <= in_data.last_pixel_in;
      div0_r  <= div_in;
    end
    if (en1) begin
      w1_r    <= w0_r;
      last1_r <= last0_r;
      div1_r  <= div0_r;
    end
    if (en2) begin
      w2_r    <= w1_r;
      last2_r <= last1_r;
      div2_r  <= div1_r;
    end
    if (en3) begin
      w3_r    <= w2_r;
      last3_r <= last2_r;
      div3_r  <= div2_r;
    end
  end

  for (genvar g = 0; g < prup_pkg::LANES; g++) begin : g_lane
    prup_lane u_lane (
      .clk    (clk),
      .en     (lane_en),
      .chan   (w0_r[8*g +: 8]),
      .alpha  (w0_r[31:24]),
      .result (lane_q[g])
    );
  end

  prup_merge u_merge (
    .clk      (clk),
    .load     (ld_out),
    .word     (w3_r),
    .last     (last3_r),
    .use_div  (div3_r),
    .lane_q   (lane_q),
    .out_data (out_data)
  );

  assign out_valid = out_v_r;

  a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ld_out) |=> (out_data.pixel_out[31:24] == $past(w3_r[31:24])))
    else $error("alpha byte changed in the merge stage");

  a_bypass_word: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !div3_r && ld_out) |=> (out_data.pixel_out == $past(w3_r)))
    else $error("bypass beat altered by the merge stage");

  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ld_out) |=> (out_data.last_pixel_out == $past(last3_r)))
    else $error("last pixel marker lost in the merge stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> in_ready)
    else $error("input stalled while the first stage is empty");

endmodule
